// ===== src/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder position controller package
// Shared types, command codes and controller constants.
// ----------------------------------------------------------------------------
`default_nettype none

package epc_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int DATA_BITS      = 16;
  localparam int DUTY_BITS      = 8;

  typedef enum logic [1:0] {
    CMD_FALL_A  = 2'd0,
    CMD_FALL_B  = 2'd1,
    CMD_COMMAND = 2'd2,
    CMD_TICK    = 2'd3
  } epc_cmd_t;

  localparam logic [7:0] OP_CLEAR = 8'h01;
  localparam logic [7:0] OP_READ  = 8'h03;
  localparam logic [7:0] OP_LOAD  = 8'h05;

  localparam logic [DUTY_BITS-1:0] CLAMP_HIGH = 8'd150;
  localparam logic [DUTY_BITS-1:0] CLAMP_SET  = 8'd100;
  localparam logic [DUTY_BITS-1:0] CLAMP_MIN  = 8'd20;

  typedef struct packed {
    epc_cmd_t              cmd;
    logic                  other_phase_level;
    logic [7:0]            opcode;
    logic [DATA_BITS-1:0]  offset_value;
  } epc_in_t;

  typedef struct packed {
    logic [DATA_BITS-1:0]  read_data;
    logic                  read_valid;
    logic [DUTY_BITS-1:0]  duty;
    logic                  direction;
    logic                  drive_enable;
    logic                  move_done;
  } epc_out_t;

endpackage

`default_nettype wire

// ===== src/encoder_position_controller_core.sv =====
// ----------------------------------------------------------------------------
// Encoder position controller core
// Quadrature edge counter with a command decoder and a clamped, slewed
// duty controller that runs a move from center toward a loaded offset.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | in_data  (epc_in_t)
//  out     | output    | out_valid / out_stall| out_data (epc_out_t)
//
//  One transaction is accepted per cycle unless in_stall is high; its result
//  passes through the input register and then the result register before it
//  is offered.
//  The controller state updates in the same cycle the result register loads.
//  Reset is synchronous and returns the count to center with the drive idle.
//  When out_stall holds a result, the input register keeps its transaction
//  and in_stall rises until the result register can advance.
// ----------------------------------------------------------------------------
`default_nettype none

module encoder_position_controller_core
  import epc_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire epc_in_t  in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output epc_out_t      out_data
);

  localparam int CW = COUNT_BITS;
  localparam logic [CW-1:0] CENTER = {1'b0, {(CW-1){1'b1}}};

  logic                  in_vld_r;
  epc_in_t               in_r;
  logic                  out_vld_r;
  epc_out_t              out_r;

  logic [CW-1:0]         pos_r,    pos_nxt;
  logic                  edge_r,   edge_nxt;
  logic [CW-1:0]         offs_r,   offs_nxt;
  logic [CW-1:0]         tgt_r,    tgt_nxt;
  logic [CW-1:0]         acc_r,    acc_nxt;
  logic [DUTY_BITS-1:0]  lerr_r,   lerr_nxt;
  logic [DUTY_BITS-1:0]  duty_r,   duty_nxt;
  logic                  dir_r,    dir_nxt;
  logic                  moving_r, moving_nxt;
  epc_out_t              res_nxt;

  logic                  fire;
  logic                  pos_gt, pos_eq;
  logic [CW-1:0]         diff, term_raw, term_sh;
  logic [DUTY_BITS-1:0]  term_c;

  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !fire;

  assign pos_gt   = pos_r > tgt_r;
  assign pos_eq   = pos_r == tgt_r;
  assign diff     = pos_gt ? (pos_r - tgt_r) : (tgt_r - pos_r);
  assign term_raw = pos_eq ? CW'(lerr_r) : (diff + acc_r);
  assign term_sh  = term_raw >> 3;

  always_comb begin
    if (term_sh > CW'(CLAMP_HIGH)) begin
      term_c = CLAMP_SET;
    end else if (term_sh <= CW'(CLAMP_MIN)) begin
      term_c = CLAMP_MIN;
    end else begin
      term_c = term_sh[DUTY_BITS-1:0];
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    edge_nxt   = edge_r;
    offs_nxt   = offs_r;
    tgt_nxt    = tgt_r;
    acc_nxt    = acc_r;
    lerr_nxt   = lerr_r;
    duty_nxt   = duty_r;
    dir_nxt    = dir_r;
    moving_nxt = moving_r;
    res_nxt    = '0;
    unique case (in_r.cmd)
      CMD_FALL_A, CMD_FALL_B: begin
        if (edge_r && !in_r.other_phase_level) begin
          edge_nxt = 1'b0;
          pos_nxt  = (in_r.cmd == CMD_FALL_B) ? (pos_r + 1'b1) : (pos_r - 1'b1);
        end else begin
          edge_nxt = 1'b1;
        end
      end
      CMD_COMMAND: begin
        if (in_r.opcode == OP_READ) begin
          res_nxt.read_data  = DATA_BITS'(pos_r);
          res_nxt.read_valid = 1'b1;
        end
        if (in_r.opcode == OP_LOAD) begin
          offs_nxt = CW'(in_r.offset_value);
        end
        pos_nxt    = CENTER;
        tgt_nxt    = CENTER - offs_nxt;
        acc_nxt    = '0;
        moving_nxt = 1'b1;
      end
      CMD_TICK: begin
        if (moving_r) begin
          if (!pos_eq) begin
            dir_nxt = pos_gt;
            acc_nxt = (acc_r + pos_r - tgt_r) >> 2;
          end else begin
            acc_nxt = acc_r >> 2;
          end
          lerr_nxt = term_c;
          if (duty_r > term_c) begin
            duty_nxt = duty_r - 1'b1;
          end else if (duty_r < term_c) begin
            duty_nxt = duty_r + 1'b1;
          end
          if (pos_eq) begin
            moving_nxt        = 1'b0;
            res_nxt.move_done = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    res_nxt.duty         = duty_nxt;
    res_nxt.direction    = dir_nxt;
    res_nxt.drive_enable = moving_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= CENTER;
      edge_r    <= 1'b0;
      offs_r    <= '0;
      tgt_r     <= '0;
      acc_r     <= '0;
      lerr_r    <= '0;
      duty_r    <= '0;
      dir_r     <= 1'b0;
      moving_r  <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_vld_r <= in_valid;
      end
      if (fire) begin
        out_vld_r <= 1'b1;
        pos_r     <= pos_nxt;
        edge_r    <= edge_nxt;
        offs_r    <= offs_nxt;
        tgt_r     <= tgt_nxt;
        acc_r     <= acc_nxt;
        lerr_r    <= lerr_nxt;
        duty_r    <= duty_nxt;
        dir_r     <= dir_nxt;
        moving_r  <= moving_nxt;
      end else if (!out_stall) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_r <= in_data;
    end
    if (fire) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_done_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.move_done |-> !out_r.drive_enable)
    else $error("A finished move still reports the drive enabled.");

  a_read_starts_move: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_r.read_valid |-> out_r.drive_enable)
    else $error("A read reply was produced without starting a move.");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_vld_r && out_vld_r && out_stall)
    else $error("Input stalled without a blocked transaction.");

  a_duty_slew: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (duty_r == $past(duty_r)) || (duty_r == $past(duty_r) + 8'd1)
                     || (duty_r == $past(duty_r) - 8'd1))
    else $error("Duty moved by more than one step.");

  a_idle_duty_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(moving_r) |-> $stable(duty_r))
    else $error("Duty changed while no move was running.");
`endif

endmodule

`default_nettype wire

// ===== verif/encoder_position_controller_core_tb.sv =====
// ----------------------------------------------------------------------------
// Encoder position controller core testbench
// Drives encoder edges, commands and control ticks through the valid/stall
// input channel and checks every result against a cycle-free model of the
// counter, the command decoder and the clamped duty controller. Both channels
// see random gaps, and one phase holds the result channel off for a long
// stretch so the core fills up and stalls its input.
// ----------------------------------------------------------------------------

module encoder_position_controller_core_tb;
  import epc_pkg::*;

  localparam int          CW             = COUNT_BITS_DEF;
  localparam logic [CW-1:0] CENTER       = (CW'(1) << (CW - 1)) - CW'(1);
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          RANDOM_GOAL    = 400;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  epc_in_t  in_data;
  logic     out_valid;
  logic     out_stall = 1'b0;
  epc_out_t out_data;

  logic [CW-1:0] pos_cnt;
  logic          edge_armed;
  logic [CW-1:0] offset_reg;
  logic [CW-1:0] target_reg;
  logic [CW-1:0] accum;
  logic [CW-1:0] prev_term;
  logic [7:0]    duty_reg;
  logic          dir_reg;
  logic          moving_reg;

  epc_out_t    expected_results[$];
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned moves_finished;
  int unsigned reads_issued;
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned rx_hold_cycles;
  int unsigned rx_stall_left;
  int unsigned rx_run_left;
  bit          tx_gaps_on = 1'b1;
  bit          rx_gaps_on = 1'b1;

  encoder_position_controller_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  task automatic reset_controller();
    pos_cnt    = CENTER;
    edge_armed = 1'b0;
    offset_reg = '0;
    target_reg = '0;
    accum      = '0;
    prev_term  = '0;
    duty_reg   = '0;
    dir_reg    = 1'b0;
    moving_reg = 1'b0;
  endtask

  function automatic epc_out_t controller_step(input epc_in_t it);
    epc_out_t      res;
    logic [CW-1:0] term;
    res = '0;
    case (it.cmd)
      CMD_FALL_A, CMD_FALL_B: begin
        if (edge_armed && !it.other_phase_level) begin
          edge_armed = 1'b0;
          if (it.cmd == CMD_FALL_B) pos_cnt = pos_cnt + CW'(1);
          else pos_cnt = pos_cnt - CW'(1);
        end else begin
          edge_armed = 1'b1;
        end
      end
      CMD_COMMAND: begin
        if (it.opcode == OP_READ) begin
          res.read_data  = pos_cnt[DATA_BITS-1:0];
          res.read_valid = 1'b1;
          reads_issued++;
        end
        if (it.opcode == OP_LOAD) offset_reg = it.offset_value;
        pos_cnt    = CENTER;
        target_reg = CENTER - offset_reg;
        accum      = '0;
        moving_reg = 1'b1;
      end
      default: begin
        if (moving_reg) begin
          term = prev_term;
          if (pos_cnt > target_reg) begin
            term    = pos_cnt - target_reg + accum;
            dir_reg = 1'b1;
          end else if (pos_cnt < target_reg) begin
            term    = target_reg - pos_cnt + accum;
            dir_reg = 1'b0;
          end
          if (pos_cnt != target_reg) accum = accum + pos_cnt - target_reg;
          accum = accum >> 2;
          term  = term >> 3;
          if (term > CLAMP_HIGH) term = CLAMP_SET;
          if (term <= CLAMP_MIN) term = CLAMP_MIN;
          prev_term = term;
          if (duty_reg > term) duty_reg = duty_reg - 8'd1;
          if (duty_reg < term) duty_reg = duty_reg + 8'd1;
          if (pos_cnt == target_reg) begin
            moving_reg    = 1'b0;
            res.move_done = 1'b1;
            moves_finished++;
          end
        end
      end
    endcase
    res.duty         = duty_reg;
    res.direction    = dir_reg;
    res.drive_enable = moving_reg;
    return res;
  endfunction

  // Returns right after the accepting edge with in_valid still high, so the
  // caller either sends again at once or lowers valid before time advances.
  task automatic send_item(input epc_in_t it);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    expected_results.push_back(controller_step(it));
  endtask

  function automatic epc_in_t rand_item(input epc_cmd_t kind);
    epc_in_t it;
    it.cmd               = kind;
    it.other_phase_level = 1'($urandom_range(0, 1));
    it.opcode            = 8'($urandom_range(0, 255));
    it.offset_value      = 16'($urandom_range(0, 65535));
    return it;
  endfunction

  task automatic send_edge(input epc_cmd_t kind, input logic level);
    epc_in_t it;
    it = rand_item(kind);
    it.other_phase_level = level;
    send_item(it);
  endtask

  task automatic send_tick();
    send_item(rand_item(CMD_TICK));
  endtask

  task automatic send_command(input logic [7:0] op, input logic [15:0] off);
    epc_in_t it;
    it = rand_item(CMD_COMMAND);
    it.opcode       = op;
    it.offset_value = off;
    send_item(it);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  task automatic test_idle_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_target_tick();
    send_command(OP_LOAD, 16'h0000);
    send_tick();
  endtask

  task automatic test_edge_flag();
    send_edge(CMD_FALL_A, 1'b1);
    send_edge(CMD_FALL_A, 1'b0);
    send_edge(CMD_FALL_B, 1'b0);
    send_edge(CMD_FALL_B, 1'b1);
    send_edge(CMD_FALL_B, 1'b0);
    send_edge(CMD_FALL_A, 1'b0);
    send_edge(CMD_FALL_B, 1'b0);
    send_command(OP_READ, 16'h0000);
  endtask

  task automatic test_opcodes();
    send_command(OP_CLEAR, 16'hFFFF);
    send_command(8'h00, 16'h1234);
    send_command(8'hFF, 16'hFFFF);
    send_command(OP_LOAD, 16'hFFFF);
    send_tick();
    send_tick();
    send_command(OP_LOAD, 16'h8000);
    send_tick();
    send_command(OP_READ, 16'h0000);
  endtask

  task automatic run_move();
    int unsigned pick;
    int unsigned budget;
    logic [7:0]  op;
    logic [15:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 75) off = 16'($urandom_range(0, 12));
    else if (pick < 85) off = 16'hFFFF - 16'($urandom_range(0, 11));
    else off = 16'($urandom_range(0, 65535));
    pick = $urandom_range(0, 99);
    if (pick < 80) op = OP_LOAD;
    else if (pick < 88) op = OP_READ;
    else if (pick < 94) op = OP_CLEAR;
    else op = 8'($urandom_range(0, 255));
    send_command(op, off);
    budget = $urandom_range(20, 80);
    while (moving_reg && budget > 0) begin
      budget--;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send_tick();
      end else if (pick < 90) begin
        send_edge((pos_cnt > target_reg) ? CMD_FALL_A : CMD_FALL_B,
                  $urandom_range(0, 9) == 0);
      end else begin
        send_edge(epc_cmd_t'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  task automatic test_random_moves(input int unsigned goal);
    while (items_sent < goal) begin
      if ($urandom_range(0, 19) == 0) wait_for_drain();
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_gaps_on = ($urandom_range(0, 4) != 0);
      run_move();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_noise();
    repeat (60) send_item(rand_item(epc_cmd_t'($urandom_range(0, 3))));
  endtask

  task automatic test_backpressure();
    int i;
    tx_gaps_on     = 1'b0;
    rx_hold_cycles = 300;
    send_command(OP_LOAD, 16'd3);
    for (i = 0; i < 30; i++) begin
      if (i % 3 == 2) send_tick();
      else send_edge(CMD_FALL_A, 1'b0);
    end
    tx_gaps_on = 1'b1;
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (rx_hold_cycles > 0) begin
      out_stall <= 1'b1;
      rx_hold_cycles--;
    end else if (!rx_gaps_on) begin
      out_stall <= 1'b0;
    end else if (rx_stall_left > 0) begin
      out_stall <= 1'b1;
      rx_stall_left--;
    end else if (rx_run_left > 0) begin
      out_stall <= 1'b0;
      rx_run_left--;
    end else begin
      out_stall     <= 1'b0;
      rx_stall_left = pick_gap();
      rx_run_left   = $urandom_range(0, 12);
    end
  end

  task automatic note_mismatch(input string field, input logic [15:0] want,
                               input logic [15:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on %s: expected %0h, got %0h", field, want, got);
  endtask

  always @(posedge clk) begin
    epc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result arrived with no transaction pending");
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        if (out_data.read_data !== want.read_data)
          note_mismatch("read_data", want.read_data, out_data.read_data);
        if (out_data.read_valid !== want.read_valid)
          note_mismatch("read_valid", 16'(want.read_valid), 16'(out_data.read_valid));
        if (out_data.duty !== want.duty)
          note_mismatch("duty", 16'(want.duty), 16'(out_data.duty));
        if (out_data.direction !== want.direction)
          note_mismatch("direction", 16'(want.direction), 16'(out_data.direction));
        if (out_data.drive_enable !== want.drive_enable)
          note_mismatch("drive_enable", 16'(want.drive_enable),
                        16'(out_data.drive_enable));
        if (out_data.move_done !== want.move_done)
          note_mismatch("move_done", 16'(want.move_done), 16'(out_data.move_done));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    reset_controller();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_idle_tick();
    test_target_tick();
    test_edge_flag();
    test_opcodes();
    test_random_moves(RANDOM_GOAL);
    test_noise();
    test_backpressure();
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d transactions sent, %0d results checked, %0d mismatches",
             items_sent, results_checked, mismatches);
    $display("%0d moves finished at target, %0d count reads", moves_finished,
             reads_issued);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
